// ----- rtl/qsds_pkg.sv -----
package qsds_pkg;

    // Point and fixed-point formats
    localparam int COORD_W  = 16;
    localparam int FRAC_W   = 8;
    localparam int AXES     = 3;
    localparam int MAG_W    = COORD_W + 1;
    localparam int Q_W      = COORD_W + 2;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int RAD_W    = 2 * ((SUM_W + 2 * FRAC_W + 1) / 2);
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 2;

    // Scale, plane and code formats
    localparam int VS_W     = 16;
    localparam int V2_W     = VS_W + 1;
    localparam int U_W      = VS_W + 1;
    localparam int T_W      = VS_W + 3;
    localparam int CODE_W   = 8;
    localparam int DIFF_W   = CODE_W + 1;
    localparam int NUM_W    = V2_W + CODE_W + 3;
    localparam int NUMMAG_W = NUM_W - 1;
    localparam int QUOT_W   = CODE_W;
    localparam int D2_W     = ROOT_W + 1;
    localparam int MP_W     = D2_W + VS_W + 1;
    localparam int SCALE_SH = 3 * FRAC_W;
    localparam int TZ_W     = MP_W - SCALE_SH;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = AXES * COORD_W;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHAPE_KIND   = 3'd0,
        REG_BOX_CENTER   = 3'd1,
        REG_BOX_HALF     = 3'd2,
        REG_VOXEL_SCALE  = 3'd3,
        REG_PLANE_OFFSET = 3'd4,
        REG_CODE_MIN     = 3'd5,
        REG_CODE_MAX     = 3'd6
    } cfg_index_t;

    typedef enum logic {
        SHAPE_PLANE = 1'b0,
        SHAPE_BOX   = 1'b1
    } shape_kind_t;

    typedef struct packed {
        shape_kind_t                kind;
        logic [CFG_DATA_W-1:0]      center;
        logic [CFG_DATA_W-1:0]      half;
        logic [VS_W-1:0]            vscale;
        logic signed [COORD_W-1:0]  poff;
        logic signed [CODE_W-1:0]   cmin;
        logic signed [CODE_W-1:0]   cmax;
    } cfg_t;

    typedef struct packed {
        logic signed [Q_W-1:0] qx;
        logic signed [Q_W-1:0] qy;
        logic signed [Q_W-1:0] qz;
        logic [U_W-1:0]        u;
    } queue_entry_t;

    typedef struct packed {
        logic [REM_W-1:0]      rem;
        logic [ROOT_W-1:0]     root;
        logic [RAD_W-1:0]      rad;
        logic signed [Q_W-1:0] qmax;
        logic [NUMMAG_W-1:0]   pmag;
        logic [QUOT_W-1:0]     pquot;
        logic                  pneg;
    } stage_t;

    // A scale of zero behaves as the smallest step
    function automatic logic [VS_W-1:0] eff_scale(input logic [VS_W-1:0] v);
        return (v == '0) ? VS_W'(1) : v;
    endfunction

    // One bit of the integer square root
    function automatic stage_t sqrt_step(input stage_t s);
        stage_t           r;
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        r     = s;
        cur   = {s.rem, s.rad[RAD_W-1 -: 2]};
        trial = {{(REM_W - ROOT_W){1'b0}}, s.root, 2'b01};
        if (cur >= trial)
        begin
            r.rem  = REM_W'(cur - trial);
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = REM_W'(cur);
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        r.rad = {s.rad[RAD_W-3:0], 2'b00};
        return r;
    endfunction

    // One quotient bit of the plane mapping divide
    function automatic stage_t div_step(input stage_t s, input logic [V2_W-1:0] d,
                                        input int k);
        stage_t              r;
        logic [NUMMAG_W-1:0] trial;
        r     = s;
        trial = NUMMAG_W'(d) << k;
        if (s.pmag >= trial)
        begin
            r.pmag  = s.pmag - trial;
            r.pquot = s.pquot | (QUOT_W'(1) << k);
        end
        return r;
    endfunction

endpackage

// ----- rtl/qsds_front.sv -----
module qsds_front (
    input  logic signed [qsds_pkg::COORD_W-1:0] point_x,
    input  logic signed [qsds_pkg::COORD_W-1:0] point_y,
    input  logic signed [qsds_pkg::COORD_W-1:0] point_z,
    input  qsds_pkg::cfg_t                      cfg,
    output qsds_pkg::queue_entry_t              entry
);
    import qsds_pkg::*;

    function automatic logic signed [Q_W-1:0] box_q(input logic signed [COORD_W-1:0] p,
                                                    input logic signed [COORD_W-1:0] c,
                                                    input logic signed [COORD_W-1:0] h);
        logic signed [COORD_W:0] diff;
        logic [COORD_W:0]        mag;
        diff = $signed({p[COORD_W-1], p}) - $signed({c[COORD_W-1], c});
        mag  = diff[COORD_W] ? (COORD_W+1)'(-diff) : diff;
        return $signed({1'b0, mag}) - $signed({{2{h[COORD_W-1]}}, h});
    endfunction

    logic [VS_W-1:0]       v;
    logic signed [T_W-1:0] vs;
    logic signed [T_W-1:0] t;

    // Plane: offset from the band center, clamp to the band
    always_comb
    begin
        v  = eff_scale(cfg.vscale);
        vs = $signed({{(T_W - VS_W){1'b0}}, v});
        t  = T_W'(point_y) - vs + T_W'(cfg.poff);
        if (t < -vs)
            t = -vs;
        if (t > vs)
            t = vs;
    end

    assign entry.u  = U_W'(t + vs);
    assign entry.qx = box_q(point_x, cfg.center[0*COORD_W +: COORD_W],
                            cfg.half[0*COORD_W +: COORD_W]);
    assign entry.qy = box_q(point_y, cfg.center[1*COORD_W +: COORD_W],
                            cfg.half[1*COORD_W +: COORD_W]);
    assign entry.qz = box_q(point_z, cfg.center[2*COORD_W +: COORD_W],
                            cfg.half[2*COORD_W +: COORD_W]);

endmodule

// ----- rtl/qsds_queue.sv -----
module qsds_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  qsds_pkg::queue_entry_t wr_entry,
    input  logic                   pop,
    output logic                   avail,
    output qsds_pkg::queue_entry_t rd_entry
);
    import qsds_pkg::*;

    queue_entry_t      mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              take;

    assign in_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign avail    = (count_reg != '0);
    assign push     = in_valid && !in_stall;
    assign take     = pop && avail;
    assign rd_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

// ----- rtl/qsds_back.sv -----
module qsds_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  qsds_pkg::cfg_t                    cfg,
    input  logic                              avail,
    input  qsds_pkg::queue_entry_t            rd_entry,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [qsds_pkg::CODE_W-1:0] distance_code
);
    import qsds_pkg::*;

    typedef struct packed {
        logic [SQ_W-1:0]         sq0;
        logic [SQ_W-1:0]         sq1;
        logic [SQ_W-1:0]         sq2;
        logic signed [Q_W-1:0]   qmax;
        logic signed [NUM_W-1:0] pa;
        logic signed [NUM_W-1:0] pb;
    } sq_stage_t;

    typedef struct packed {
        logic signed [MP_W-1:0]   prod;
        logic signed [QUOT_W:0]   pres;
    } mul_stage_t;

    localparam logic signed [MP_W-1:0] TRUNC_BIAS = MP_W'((64'd1 << SCALE_SH) - 64'd1);

    logic                   adv;
    logic [VS_W-1:0]        v;
    logic [V2_W-1:0]        v2;

    logic                   a_valid_reg;
    sq_stage_t              a_reg, a_next;
    logic [ROOT_W:0]        vld_reg;
    stage_t                 pipe_reg [ROOT_W+1];
    stage_t                 pipe0_next;
    stage_t                 stage_next [ROOT_W];
    logic                   m_valid_reg;
    mul_stage_t             m_reg, m_next;
    logic                   out_valid_reg;
    logic signed [CODE_W-1:0] code_reg, code_next;

    // Whole back end moves together; it holds only while the result waits
    assign adv = !out_valid_reg || !out_stall;
    assign pop = adv && avail;
    assign v   = eff_scale(cfg.vscale);
    assign v2  = {v, 1'b0};

    // Squares of the outside distances, nearest-face term, plane products
    always_comb
    begin
        logic [MAG_W-1:0]         p0, p1, p2;
        logic signed [DIFF_W-1:0] dd;
        p0 = (rd_entry.qx > 0) ? MAG_W'(rd_entry.qx) : '0;
        p1 = (rd_entry.qy > 0) ? MAG_W'(rd_entry.qy) : '0;
        p2 = (rd_entry.qz > 0) ? MAG_W'(rd_entry.qz) : '0;
        a_next.sq0  = SQ_W'(p0) * SQ_W'(p0);
        a_next.sq1  = SQ_W'(p1) * SQ_W'(p1);
        a_next.sq2  = SQ_W'(p2) * SQ_W'(p2);
        a_next.qmax = rd_entry.qx;
        if (rd_entry.qy > a_next.qmax)
            a_next.qmax = rd_entry.qy;
        if (rd_entry.qz > a_next.qmax)
            a_next.qmax = rd_entry.qz;
        dd        = DIFF_W'(cfg.cmax) - DIFF_W'(cfg.cmin);
        a_next.pa = NUM_W'(cfg.cmin) * NUM_W'($signed({1'b0, v2}));
        a_next.pb = NUM_W'($signed({1'b0, rd_entry.u})) * NUM_W'(dd);
    end

    // Radicand and divide operands
    always_comb
    begin
        logic [SUM_W-1:0]        sum;
        logic signed [NUM_W-1:0] num;
        sum = SUM_W'(a_reg.sq0) + SUM_W'(a_reg.sq1) + SUM_W'(a_reg.sq2);
        num = a_reg.pa + a_reg.pb;
        pipe0_next.rem   = '0;
        pipe0_next.root  = '0;
        pipe0_next.rad   = RAD_W'({sum, {(2 * FRAC_W){1'b0}}});
        pipe0_next.qmax  = a_reg.qmax;
        pipe0_next.pneg  = num[NUM_W-1];
        pipe0_next.pmag  = num[NUM_W-1] ? NUMMAG_W'(-num) : NUMMAG_W'(num);
        pipe0_next.pquot = '0;
    end

    // One root bit per stage; the first stages also yield one quotient bit
    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_step
        if (i < QUOT_W)
        begin : g_div
            assign stage_next[i] = div_step(sqrt_step(pipe_reg[i]), v2, QUOT_W - 1 - i);
        end
        else
        begin : g_root
            assign stage_next[i] = sqrt_step(pipe_reg[i]);
        end
    end

    // Box distance times scale; signed plane quotient
    always_comb
    begin
        logic signed [D2_W-1:0] d2;
        if (pipe_reg[ROOT_W].qmax > 0)
            d2 = $signed({1'b0, pipe_reg[ROOT_W].root});
        else
            d2 = D2_W'(pipe_reg[ROOT_W].qmax) <<< FRAC_W;
        m_next.prod = MP_W'(d2) * MP_W'($signed({1'b0, v}));
        m_next.pres = pipe_reg[ROOT_W].pneg ? -$signed({1'b0, pipe_reg[ROOT_W].pquot})
                                            : $signed({1'b0, pipe_reg[ROOT_W].pquot});
    end

    // Truncate toward zero, clamp the box code, pick the shape
    always_comb
    begin
        logic signed [TZ_W-1:0] tz;
        if (m_reg.prod[MP_W-1])
            tz = TZ_W'((m_reg.prod + TRUNC_BIAS) >>> SCALE_SH);
        else
            tz = TZ_W'(m_reg.prod >>> SCALE_SH);
        if (tz < TZ_W'(cfg.cmin))
            tz = TZ_W'(cfg.cmin);
        if (tz > TZ_W'(cfg.cmax))
            tz = TZ_W'(cfg.cmax);
        if (cfg.kind == SHAPE_BOX)
            code_next = CODE_W'(tz);
        else
            code_next = CODE_W'(m_reg.pres);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            vld_reg       <= '0;
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= avail;
            vld_reg       <= {vld_reg[ROOT_W-1:0], a_valid_reg};
            m_valid_reg   <= vld_reg[ROOT_W];
            out_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg       <= a_next;
            pipe_reg[0] <= pipe0_next;
            for (int i = 0; i < ROOT_W; i++)
                pipe_reg[i+1] <= stage_next[i];
            m_reg       <= m_next;
            code_reg    <= code_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign distance_code = code_reg;

endmodule

// ----- rtl/quantized_shape_distance_sampler_unit.sv -----
// Shape distance sampler: each point transaction (signed Q8.8 x, y, z) gives
// one signed 8-bit distance code for the shape held in the configuration
// registers, a horizontal plane band or an axis-aligned box. Results leave
// in the order points arrive. One point is taken per clock cycle while
// in_stall is low, and one code leaves per cycle while the output is not
// stalled; a point's code passes through the queue, the square stage, the
// 26-stage square-root pipeline of the box length, the scale multiply and
// the clamp stage.
// A four-entry queue sits between the point classifier and the arithmetic
// pipeline, so in_stall rises only once the output has been stalled long
// enough to fill it. Write configuration only while no point is in flight.
// Register indexes: 0 shape kind (0 plane, 1 box), 1 box center, 2 box half
// extent (three packed 16-bit fields, x lowest), 3 voxel scale, 4 plane offset,
// 5 code min, 6 code max; other indexes are ignored. cfg_ready is always high.
module quantized_shape_distance_sampler_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [qsds_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [qsds_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [qsds_pkg::COORD_W-1:0]  point_x,
    input  logic signed [qsds_pkg::COORD_W-1:0]  point_y,
    input  logic signed [qsds_pkg::COORD_W-1:0]  point_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [qsds_pkg::CODE_W-1:0]   distance_code
);
    import qsds_pkg::*;

    shape_kind_t               kind_reg;
    logic [CFG_DATA_W-1:0]     center_reg;
    logic [CFG_DATA_W-1:0]     half_reg;
    logic [VS_W-1:0]           vscale_reg;
    logic signed [COORD_W-1:0] poff_reg;
    logic signed [CODE_W-1:0]  cmin_reg;
    logic signed [CODE_W-1:0]  cmax_reg;
    cfg_t                      cfg;

    queue_entry_t              wr_entry;
    queue_entry_t              rd_entry;
    logic                      avail;
    logic                      pop;

    // Always accept a configuration transaction
    assign cfg_ready = 1'b1;

    // Decode register writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= SHAPE_PLANE;
            center_reg <= '0;
            half_reg   <= '0;
            vscale_reg <= VS_W'(256);
            poff_reg   <= '0;
            cmin_reg   <= -CODE_W'(127);
            cmax_reg   <= CODE_W'(127);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                REG_SHAPE_KIND:   kind_reg   <= shape_kind_t'(cfg_data[0]);
                REG_BOX_CENTER:   center_reg <= cfg_data;
                REG_BOX_HALF:     half_reg   <= cfg_data;
                REG_VOXEL_SCALE:  vscale_reg <= cfg_data[VS_W-1:0];
                REG_PLANE_OFFSET: poff_reg   <= cfg_data[COORD_W-1:0];
                REG_CODE_MIN:     cmin_reg   <= cfg_data[CODE_W-1:0];
                REG_CODE_MAX:     cmax_reg   <= cfg_data[CODE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        cfg.kind   = kind_reg;
        cfg.center = center_reg;
        cfg.half   = half_reg;
        cfg.vscale = vscale_reg;
        cfg.poff   = poff_reg;
        cfg.cmin   = cmin_reg;
        cfg.cmax   = cmax_reg;
    end

    // Front: per-axis outside distances and the clamped plane position
    qsds_front u_front (
        .point_x (point_x),
        .point_y (point_y),
        .point_z (point_z),
        .cfg     (cfg),
        .entry   (wr_entry)
    );

    // Decouple the front from the arithmetic pipeline
    qsds_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .wr_entry (wr_entry),
        .pop      (pop),
        .avail    (avail),
        .rd_entry (rd_entry)
    );

    // Back: squares, root, scale, clamp; plane divide runs alongside
    qsds_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .avail         (avail),
        .rd_entry      (rd_entry),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .distance_code (distance_code)
    );

endmodule
